/* rtl/pmpt_pkg.sv */
// Package with shared types, constants and helpers of the PS/2 mouse packet tracker.
`default_nettype none
package pmpt_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SUM_W   = COORD_W + 2;

  localparam int unsigned SYNC_BIT = 3;

  localparam logic [COORD_W-1:0] XLIM_RESET = 10'd1023;
  localparam logic [COORD_W-1:0] YLIM_RESET = 10'd711;
  localparam logic [COORD_W-1:0] START_X    = 10'd512;
  localparam logic [COORD_W-1:0] START_Y    = 10'd360;

  // Register index, taken from paddr[2].
  localparam logic REG_X_LIMIT = 1'b0;
  localparam logic REG_Y_LIMIT = 1'b1;

  // Packet phase codes.
  localparam logic [1:0] PH_BTN = 2'd0;
  localparam logic [1:0] PH_DX  = 2'd1;
  localparam logic [1:0] PH_DY  = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    coord_t x_limit;
    coord_t y_limit;
  } cfg_t;

  // Saturates a signed sum to the range 0 .. limit.
  function automatic coord_t clamp_coord(input sum_t v, input coord_t limit);
    coord_t r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v[SUM_W-2:0] > {1'b0, limit}) begin
      r = limit;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/pmpt_if.sv */
// Interfaces of the input byte channel and the cursor result channel.
`default_nettype none
interface pmpt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       from_aux;

  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface pmpt_pos_if;
  logic       valid;
  logic       ready;
  logic [9:0] pos_x;
  logic [9:0] pos_y;
  logic [2:0] buttons;

  modport source (output valid, output pos_x, output pos_y, output buttons, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input buttons, output ready);
endinterface
`default_nettype wire

/* rtl/ps2_mouse_packet_tracker.sv */
// Top level of the PS/2 mouse packet tracker.
`default_nettype none
// The tracker takes one word per handshake from a PS/2 controller: the data
// byte and a flag that marks bytes from the mouse port. Keyboard words are
// dropped without effect. Mouse words are gathered into the usual three-byte
// packet; a first byte is only taken when its sync bit (bit 3) is set, so the
// block locks back onto packet boundaries by itself. When the Y byte arrives,
// the signed X delta is added to the cursor X and the signed Y delta is
// subtracted from the cursor Y (screen down is positive); each coordinate is
// clamped to 0 and to its limit register, and one result word carries the new
// position and the three button bits. Overflow and ninth sign bits are not
// used. After reset the cursor sits at (512, 360) with limits 1023 and 711.
// Each word is held in the input register and its result is registered in the
// output register in the cycle after, so one word is accepted every clock;
// the only stall is when a completed packet meets a result still waiting to be
// taken. The limit registers sit at byte addresses 0 (x_limit) and 4
// (y_limit) and should only be written while no word is in flight.
module ps2_mouse_packet_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pmpt_byte_if.sink                        pkt_byte,
  pmpt_pos_if.source                       cursor,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pmpt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pmpt_pkg::DATA_W-1:0] pwdata,
  output logic      [pmpt_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import pmpt_pkg::*;

  cfg_t cfg;

  // Limit registers.
  pmpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Packet assembly and cursor datapath.
  pmpt_packet u_packet (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pkt_byte (pkt_byte),
    .cursor   (cursor)
  );

endmodule
`default_nettype wire

/* rtl/pmpt_cfg.sv */
// APB-style register file holding the cursor limits.
`default_nettype none
module pmpt_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pmpt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pmpt_pkg::DATA_W-1:0] pwdata,
  output logic      [pmpt_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output pmpt_pkg::cfg_t                  cfg
);
  import pmpt_pkg::*;

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_limit <= XLIM_RESET;
      cfg.y_limit <= YLIM_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_X_LIMIT: cfg.x_limit <= pwdata[COORD_W-1:0];
        REG_Y_LIMIT: cfg.y_limit <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_LIMIT: prdata = {{(DATA_W-COORD_W){1'b0}}, cfg.x_limit};
      REG_Y_LIMIT: prdata = {{(DATA_W-COORD_W){1'b0}}, cfg.y_limit};
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/pmpt_packet.sv */
// Input register, packet assembly, cursor update and result register.
`default_nettype none
module pmpt_packet (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pmpt_pkg::cfg_t cfg,
  pmpt_byte_if.sink           pkt_byte,
  pmpt_pos_if.source          cursor
);
  import pmpt_pkg::*;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_aux;

  // Packet state.
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] first_byte;
  logic [7:0] delta_x_byte;
  coord_t     cur_x;
  coord_t     cur_y;

  // Result register.
  logic       ov;
  coord_t     out_x;
  coord_t     out_y;
  logic [2:0] out_btn;

  logic   emit;
  logic   advance;
  sum_t   sum_x;
  sum_t   sum_y;
  coord_t new_x;
  coord_t new_y;

  always_comb begin
    sum_x = sum_t'({2'b00, cur_x}) + sum_t'(signed'(delta_x_byte));
    sum_y = sum_t'({2'b00, cur_y}) - sum_t'(signed'(s1_data));
    new_x = clamp_coord(sum_x, cfg.x_limit);
    new_y = clamp_coord(sum_y, cfg.y_limit);
  end

  always_comb begin
    emit       = 1'b0;
    phase_next = phase;
    if (s1_aux) begin
      case (phase)
        PH_DX: phase_next = PH_DY;
        PH_DY: begin
          phase_next = PH_BTN;
          emit       = 1'b1;
        end
        default: phase_next = s1_data[SYNC_BIT] ? PH_DX : PH_BTN;
      endcase
    end
  end

  // An item leaves the input register unless it makes a result that cannot land.
  assign advance        = s1_valid && (!emit || !ov || cursor.ready);
  assign pkt_byte.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt_byte.ready) begin
      s1_valid <= pkt_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_byte.valid && pkt_byte.ready) begin
      s1_data <= pkt_byte.data_byte;
      s1_aux  <= pkt_byte.from_aux;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_BTN;
      first_byte   <= '0;
      delta_x_byte <= '0;
      cur_x        <= START_X;
      cur_y        <= START_Y;
    end else if (advance && s1_aux) begin
      phase <= phase_next;
      if (phase == PH_DX) begin
        delta_x_byte <= s1_data;
      end else if (phase == PH_DY) begin
        cur_x <= new_x;
        cur_y <= new_y;
      end else if (s1_data[SYNC_BIT]) begin
        first_byte <= s1_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (advance && emit) begin
      ov <= 1'b1;
    end else if (cursor.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_x   <= new_x;
      out_y   <= new_y;
      out_btn <= first_byte[BTN_W-1:0];
    end
  end

  assign cursor.valid   = ov;
  assign cursor.pos_x   = out_x;
  assign cursor.pos_y   = out_y;
  assign cursor.buttons = out_btn;

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (ov && phase == PH_BTN))
    else $error("completed packet did not reach the result register");

  a_sync_starts: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_aux && phase == PH_BTN && s1_data[SYNC_BIT]) |=> (phase == PH_DX))
    else $error("synced button byte did not start a packet");

  a_kbd_ignored: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_aux) |=> ($stable(phase) && $stable(cur_x) && $stable(cur_y)))
    else $error("keyboard word changed the packet state");

  a_no_emit_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !emit) |-> pkt_byte.ready)
    else $error("word without a result held the input");

endmodule
`default_nettype wire
